// ===== hdl/lpfd_pkg.sv =====
// lpfd_pkg: shared types and constants for the length-prefixed frame deframer
// no dependencies
`default_nettype none

package lpfd_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned IndexW   = 16;
  localparam int unsigned LenW     = 32;
  localparam int unsigned LimitW   = 16;
  localparam int unsigned LenBytes = 4;

  localparam logic [ByteW-1:0]  SyncByte0    = 8'h00;
  localparam logic [ByteW-1:0]  SyncByte1    = 8'h01;
  localparam logic [LimitW-1:0] LimitDefault = 16'd255;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_SYNC = 2'd1,
    PH_LEN  = 2'd2,
    PH_DATA = 2'd3
  } phase_e;

  typedef struct packed {
    logic              frame_end;
    logic [IndexW-1:0] payload_index;
    logic [ByteW-1:0]  payload_byte;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/length_prefixed_frame_deframer.sv =====
// length_prefixed_frame_deframer: one byte per word in, payload words out
// a payload word is registered into the output register, or into the skid stage while the output is held
// throughput: one word per cycle; the skid stage behind the output register takes one word
// while the output stalls, and input waits only while the skid is full
// reset: asynchronous active low, back to hunting, limit 255, buffers empty
// depends on lpfd_pkg, lpfd_parser, lpfd_out_buf
`default_nettype none

module length_prefixed_frame_deframer (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [15:0] cfg_wdata_i,     // max_payload
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [7:0]  s_axis_tdata_i,  // [7:0] rx_byte
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // [7:0] payload_byte, [23:8] payload_index
  output logic        m_axis_tlast_o   // frame_end
);
  import lpfd_pkg::*;

  logic    in_accept;
  logic    res_valid;
  result_t res;
  result_t out_data;
  phase_e  phase;
  logic    space;
  logic    skid_valid;

  assign s_axis_tready_o = space;
  assign in_accept       = s_axis_tvalid_i && space;

  lpfd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_accept),
    .in_byte_i   (s_axis_tdata_i),
    .res_valid_o (res_valid),
    .res_o       (res),
    .phase_o     (phase)
  );

  lpfd_out_buf u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (res_valid),
    .push_data_i  (res),
    .space_o      (space),
    .out_valid_o  (m_axis_tvalid_o),
    .out_data_o   (out_data),
    .out_ready_i  (m_axis_tready_i),
    .skid_valid_o (skid_valid)
  );

  assign m_axis_tdata_o = {out_data.payload_index, out_data.payload_byte};
  assign m_axis_tlast_o = out_data.frame_end;

`ifndef SYNTHESIS
  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid |-> m_axis_tvalid_o)
    else $error("skid word held with empty output register");

  a_data_word_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && phase == PH_DATA) |=> m_axis_tvalid_o)
    else $error("accepted payload word produced no output");

  a_end_to_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && phase == PH_DATA && res.frame_end) |=> phase == PH_HUNT)
    else $error("frame end did not return to hunting");

  a_header_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase != PH_DATA) |-> !res_valid)
    else $error("result raised outside the payload phase");
`endif

endmodule

`default_nettype wire

// ===== hdl/lpfd_parser.sv =====
// lpfd_parser: sync hunt, length header and payload counting, one word per cycle
// depends on lpfd_pkg
`default_nettype none

module lpfd_parser (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       cfg_we_i,
  input  wire [lpfd_pkg::LimitW-1:0] cfg_wdata_i,
  input  wire                       in_valid_i,
  input  wire [lpfd_pkg::ByteW-1:0] in_byte_i,
  output logic                      res_valid_o,
  output lpfd_pkg::result_t         res_o,
  output lpfd_pkg::phase_e          phase_o
);
  import lpfd_pkg::*;

  phase_e              phase_q, phase_d;
  logic [LenW-1:0]     len_q, len_d;
  logic [IndexW-1:0]   count_q, count_d;
  logic [LimitW-1:0]   limit_q;

  logic [IndexW:0]     cnt_next;
  logic [LimitW-1:0]   limit_m1;
  logic                end_by_len;
  logic                end_by_limit;
  logic                is_end;

  assign cnt_next     = {1'b0, count_q} + (IndexW+1)'(1);
  assign limit_m1     = limit_q - LimitW'(1);
  assign end_by_len   = LenW'(cnt_next) >= len_q;
  // one place of the buffer is kept for a terminator
  assign end_by_limit = (limit_q <= LimitW'(1)) || (cnt_next >= {1'b0, limit_m1});
  assign is_end       = end_by_len || end_by_limit;

  always_comb begin
    phase_d     = phase_q;
    len_d       = len_q;
    count_d     = count_q;
    res_valid_o = 1'b0;
    res_o.payload_byte  = in_byte_i;
    res_o.payload_index = count_q;
    res_o.frame_end     = is_end;
    if (in_valid_i) begin
      unique case (phase_q)
        PH_HUNT: begin
          if (in_byte_i == SyncByte0) phase_d = PH_SYNC;
        end
        PH_SYNC: begin
          if (in_byte_i == SyncByte1) begin
            phase_d = PH_LEN;
            len_d   = '0;
            count_d = '0;
          end else begin
            phase_d = PH_HUNT;
          end
        end
        PH_LEN: begin
          len_d = {len_q[LenW-ByteW-1:0], in_byte_i};
          if (count_q + IndexW'(1) >= IndexW'(LenBytes)) begin
            count_d = '0;
            phase_d = PH_DATA;
          end else begin
            count_d = count_q + IndexW'(1);
          end
        end
        PH_DATA: begin
          res_valid_o = 1'b1;
          if (is_end) begin
            count_d = '0;
            phase_d = PH_HUNT;
          end else begin
            count_d = cnt_next[IndexW-1:0];
          end
        end
        default: phase_d = PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      len_q   <= '0;
      count_q <= '0;
      limit_q <= LimitDefault;
    end else begin
      phase_q <= phase_d;
      len_q   <= len_d;
      count_q <= count_d;
      if (cfg_we_i) limit_q <= cfg_wdata_i;
    end
  end

  assign phase_o = phase_q;

endmodule

`default_nettype wire

// ===== hdl/lpfd_out_buf.sv =====
// lpfd_out_buf: result register with a skid stage behind it
// depends on lpfd_pkg
`default_nettype none

module lpfd_out_buf (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push_i,
  input  wire lpfd_pkg::result_t push_data_i,
  output logic               space_o,
  output logic               out_valid_o,
  output lpfd_pkg::result_t  out_data_o,
  input  wire                out_ready_i,
  output logic               skid_valid_o
);
  import lpfd_pkg::*;

  logic    main_valid_q, skid_valid_q;
  result_t main_q, skid_q;
  logic    pop;

  assign pop = main_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      // input is held off while the skid word waits
      if (pop) skid_valid_q <= 1'b0;
    end else if (push_i) begin
      if (main_valid_q && !pop) skid_valid_q <= 1'b1;
      else main_valid_q <= 1'b1;
    end else if (pop) begin
      main_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) main_q <= skid_q;
    end else if (push_i) begin
      if (main_valid_q && !pop) skid_q <= push_data_i;
      else main_q <= push_data_i;
    end
  end

  assign space_o      = !skid_valid_q;
  assign out_valid_o  = main_valid_q;
  assign out_data_o   = main_q;
  assign skid_valid_o = skid_valid_q;

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// tb_top: self-checking bench for length_prefixed_frame_deframer, driven over the byte stream
// a scoreboard model predicts each untyped word; depends on lpfd_pkg and the deframer rtl
`default_nettype none

module tb_top;
  import lpfd_pkg::*;

  localparam int unsigned ClkHalf     = 4;
  localparam int unsigned ResetCycles = 12;
  localparam int unsigned RandBytes   = 450;
  localparam int unsigned LongStall   = 300;
  localparam int unsigned SettleWait  = 4;
  localparam int unsigned DrainWait   = 10;
  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned MaxGap      = 10;
  localparam logic [31:0] HugeLen     = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    logic       has_word;
    result_t    word;
  } dir_row_t;

  localparam result_t NoWord = '0;
  localparam int NumDir = 21;
  // reset limit 255 throughout; header rows are left to the model
  localparam dir_row_t DirRows [NumDir] = '{
    '{SyncByte0, 1'b0, 1'b0, NoWord},
    '{SyncByte1, 1'b0, 1'b0, NoWord},
    '{8'h00,     1'b0, 1'b0, NoWord},
    '{8'h00,     1'b0, 1'b0, NoWord},
    '{8'h00,     1'b0, 1'b0, NoWord},
    '{8'h03,     1'b0, 1'b0, NoWord},
    '{8'h00,     1'b1, 1'b1, '{1'b0, 16'd0, 8'h00}},
    '{8'h80,     1'b1, 1'b1, '{1'b0, 16'd1, 8'h80}},
    '{8'hFF,     1'b1, 1'b1, '{1'b1, 16'd2, 8'hFF}},
    // repeated first sync byte drops back to hunting, and is not a new start
    '{SyncByte0, 1'b1, 1'b0, NoWord},
    '{SyncByte0, 1'b1, 1'b0, NoWord},
    '{SyncByte1, 1'b1, 1'b0, NoWord},
    '{SyncByte0, 1'b1, 1'b0, NoWord},
    '{8'h07,     1'b1, 1'b0, NoWord},
    // zero length still carries one byte
    '{SyncByte0, 1'b0, 1'b0, NoWord},
    '{SyncByte1, 1'b0, 1'b0, NoWord},
    '{8'h00,     1'b0, 1'b0, NoWord},
    '{8'h00,     1'b0, 1'b0, NoWord},
    '{8'h00,     1'b0, 1'b0, NoWord},
    '{8'h00,     1'b0, 1'b0, NoWord},
    '{8'h7E,     1'b1, 1'b1, '{1'b1, 16'd0, 8'h7E}}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  wire         s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  wire         m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  wire  [23:0] m_axis_tdata;
  wire         m_axis_tlast;

  length_prefixed_frame_deframer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  // scoreboard model state
  phase_e      rx_phase  = PH_HUNT;
  logic [31:0] frame_len = '0;
  logic [15:0] frame_pos = '0;
  logic [15:0] limit_now = LimitDefault;
  result_t     payload_q [$];

  int unsigned mismatches = 0;
  int unsigned bytes_fed  = 0;
  int unsigned cycle_cnt  = 0;
  bit          send_calm  = 1'b0;
  bit          recv_calm  = 1'b0;
  bit          stall_req  = 1'b0;

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic deframe_step(input logic [7:0] b, output bit got, output result_t w);
    logic [31:0] cnt;
    got = 1'b0;
    w   = '0;
    case (rx_phase)
      PH_HUNT: begin
        if (b == SyncByte0) rx_phase = PH_SYNC;
      end
      PH_SYNC: begin
        if (b == SyncByte1) begin
          rx_phase  = PH_LEN;
          frame_len = '0;
          frame_pos = '0;
        end else begin
          rx_phase = PH_HUNT;
        end
      end
      PH_LEN: begin
        frame_len = {frame_len[23:0], b};
        frame_pos = frame_pos + 16'd1;
        if (frame_pos >= LenBytes) begin
          frame_pos = '0;
          rx_phase  = PH_DATA;
        end
      end
      default: begin
        cnt = {16'd0, frame_pos} + 32'd1;
        got = 1'b1;
        w.payload_byte  = b;
        w.payload_index = frame_pos;
        // one place of the buffer is kept for a terminator
        w.frame_end = (cnt >= frame_len) || (limit_now <= 16'd1) ||
                      (cnt >= {16'd0, limit_now} - 32'd1);
        if (w.frame_end) begin
          frame_pos = '0;
          rx_phase  = PH_HUNT;
        end else begin
          frame_pos = cnt[15:0];
        end
      end
    endcase
  endtask

  // leaves tvalid high after the accepting edge; a later gap or an idle step lowers it
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = send_calm ? 0 : $urandom_range(0, MaxGap);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_fed++;
  endtask

  task automatic feed(input logic [7:0] b);
    bit      got;
    result_t w;
    send_byte(b);
    deframe_step(b, got, w);
    if (got) payload_q.push_back(w);
  endtask

  task automatic drain_frame(input int unsigned cap);
    int unsigned n;
    n = 0;
    while (rx_phase == PH_DATA && n < cap) begin
      feed(8'($urandom));
      n++;
    end
  endtask

  task automatic run_frame(input logic [31:0] len, input int unsigned cap);
    feed(SyncByte0);
    feed(SyncByte1);
    for (int i = 3; i >= 0; i--) feed(len[8*i +: 8]);
    drain_frame(cap);
  endtask

  // only with nothing in flight; a header byte leaves no word to wait for, hence the settle
  task automatic set_limit(input logic [15:0] v);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    wait (payload_q.size() == 0);
    repeat (SettleWait) @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk_i);
    cfg_we    = 1'b0;
    limit_now = v;
  endtask

  function automatic logic [15:0] pick_limit();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, 3));
      1:       return 16'($urandom_range(4, 40));
      2:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_len();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return $urandom;
      2:       return 32'($urandom_range(17, 300));
      default: return 32'($urandom_range(1, 16));
    endcase
  endfunction

  initial begin : stimulus
    bit          got;
    result_t     w;
    int unsigned start;
    int unsigned next_cfg;
    int unsigned cut;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (DirRows[i]) begin
      send_byte(DirRows[i].rx);
      deframe_step(DirRows[i].rx, got, w);
      if (DirRows[i].typed) begin
        if (DirRows[i].has_word) payload_q.push_back(DirRows[i].word);
      end else if (got) begin
        payload_q.push_back(w);
      end
    end

    // tiny limits cut every frame to one byte
    set_limit(16'd1);
    run_frame(32'd5, 400);
    set_limit(16'd0);
    run_frame(32'd0, 400);
    run_frame(32'd9, 400);
    set_limit(16'd2);
    run_frame(32'd9, 400);
    // unsigned compare: the limit ends a huge frame
    set_limit(16'd3);
    run_frame(HugeLen, 400);

    // limit lowered in the middle of a frame
    set_limit(16'd255);
    run_frame(32'd100, 10);
    set_limit(16'd5);
    drain_frame(400);

    // output held off for a long stretch while input keeps coming
    set_limit(16'd255);
    send_calm = 1'b1;
    stall_req = 1'b1;
    run_frame(32'd200, 400);

    // widest limit, no gaps on either side
    set_limit(16'hFFFF);
    recv_calm = 1'b1;
    run_frame(HugeLen, 40);
    send_calm = 1'b0;
    recv_calm = 1'b0;

    start    = bytes_fed;
    next_cfg = 0;
    while (bytes_fed - start < RandBytes) begin
      if (bytes_fed - start >= next_cfg) begin
        set_limit(pick_limit());
        send_calm = ($urandom_range(0, 3) == 0);
        recv_calm = ($urandom_range(0, 3) == 0);
        next_cfg += 100;
      end
      if ($urandom_range(0, 4) != 0) begin
        // some frames are cut short so the rest of the stream lands in the payload
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 5) : 120;
        run_frame(pick_len(), cut);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 2) == 0) feed(8'($urandom_range(0, 1)));
          else feed(8'($urandom));
        end
      end
    end

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    wait (payload_q.size() == 0);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("length_prefixed_frame_deframer verification clean");
    end else begin
      $display("length_prefixed_frame_deframer verification failed");
    end
    $finish;
  end

  initial begin : drain_side
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_req) begin
        m_axis_tready = 1'b0;
        stall_req     = 1'b0;
        repeat (LongStall) @(negedge clk_i);
      end
      gap = recv_calm ? 0 : $urandom_range(0, MaxGap);
      if (gap > 0) begin
        m_axis_tready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin : check_out
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (payload_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected word data %h last %b", m_axis_tdata, m_axis_tlast));
      end else begin
        want = payload_q.pop_front();
        if (m_axis_tdata[7:0] !== want.payload_byte)
          flag_mismatch($sformatf("payload_byte %h, want %h", m_axis_tdata[7:0],
                                  want.payload_byte));
        if (m_axis_tdata[23:8] !== want.payload_index)
          flag_mismatch($sformatf("payload_index %0d, want %0d", m_axis_tdata[23:8],
                                  want.payload_index));
        if (m_axis_tlast !== want.frame_end)
          flag_mismatch($sformatf("frame_end %b, want %b at index %0d", m_axis_tlast,
                                  want.frame_end, want.payload_index));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("length_prefixed_frame_deframer verification failed");
      $finish;
    end
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/lpfd_pkg.sv
hdl/lpfd_parser.sv
hdl/lpfd_out_buf.sv
hdl/length_prefixed_frame_deframer.sv
test/tb_top.sv
